FILE: hw/rtl/polynomial_add_sub_mul_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the polynomial sum, difference and product block.
// Each macro expands to one labeled concurrent assertion on a clock edge,
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef POLYNOMIAL_ADD_SUB_MUL_DEFINES_SVH
`define POLYNOMIAL_ADD_SUB_MUL_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define PASM_ASSERT_SAME(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("pasm assertion failed");

// The condition must hold in the cycle after the trigger.
`define PASM_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("pasm assertion failed");

`endif

FILE: hw/rtl/pasm_pkg.sv
// ----------------------------------------------------------------------------
// pasm_pkg
// Shared constants, register indexes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package pasm_pkg;

    // Default configuration of the block.
    localparam int MAX_DEGREE  = 31;
    localparam int COEF_WIDTH  = 16;

    // Fixed field widths.
    localparam int POWER_W     = 5;
    localparam int OUT_POWER_W = 6;
    localparam int DEG_W       = 5;
    localparam int CFG_INDEX_W = 1;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FIRST_DEGREE  = 1'b0,
        CFG_SECOND_DEGREE = 1'b1
    } t_cfg_index;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                   store_we;    // write both stores at addr_i
        logic                   term_en;     // issue one product term
        logic                   term_first;  // first term of this power
        logic [POWER_W-1:0]     addr_i;      // first store index (or write index)
        logic [POWER_W-1:0]     addr_j;      // second store index of the term
        logic [POWER_W-1:0]     addr_k;      // index of the current power
        logic                   k_in_first;  // power within first degree
        logic                   k_in_second; // power within second degree
        logic                   capture;     // load the result register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pipe_busy;  // product terms still in flight
    } t_dp_status;

endpackage

`default_nettype wire

FILE: hw/rtl/pasm_datapath.sv
// ----------------------------------------------------------------------------
// pasm_datapath
// Coefficient stores, multiply-accumulate pipeline and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pasm_datapath #(
    parameter int MAX_DEGREE = pasm_pkg::MAX_DEGREE,
    parameter int COEF_WIDTH = pasm_pkg::COEF_WIDTH
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  pasm_pkg::t_dp_cmd                      i_cmd,
    input  wire logic signed [COEF_WIDTH-1:0]      i_first_coef,
    input  wire logic signed [COEF_WIDTH-1:0]      i_second_coef,
    output pasm_pkg::t_dp_status                   o_status,
    output logic signed [COEF_WIDTH:0]             o_sum_coef,
    output logic signed [COEF_WIDTH:0]             o_diff_coef,
    output logic signed [2*COEF_WIDTH+pasm_pkg::POWER_W-1:0] o_prod_coef
);
    import pasm_pkg::*;

    localparam int DEPTH  = MAX_DEGREE + 1;
    localparam int SUM_W  = COEF_WIDTH + 1;
    localparam int MUL_W  = 2 * COEF_WIDTH;
    localparam int PROD_W = 2 * COEF_WIDTH + POWER_W;

    logic signed [COEF_WIDTH-1:0] r_first_mem  [0:DEPTH-1];
    logic signed [COEF_WIDTH-1:0] r_second_mem [0:DEPTH-1];

    logic signed [COEF_WIDTH-1:0] r_rd_a;
    logic signed [COEF_WIDTH-1:0] r_rd_b;
    logic signed [COEF_WIDTH-1:0] r_a_k;
    logic signed [COEF_WIDTH-1:0] r_b_k;
    logic                         r_v1;
    logic                         r_f1;
    logic                         r_v2;
    logic                         r_f2;
    logic signed [MUL_W-1:0]      r_prod;
    logic signed [PROD_W-1:0]     r_acc;
    logic signed [SUM_W-1:0]      r_sum;
    logic signed [SUM_W-1:0]      r_diff;
    logic signed [PROD_W-1:0]     r_out_prod;

    logic signed [COEF_WIDTH-1:0] a_k_masked;
    logic signed [COEF_WIDTH-1:0] b_k_masked;

    // Coefficient stores: one write port, two registered read ports each.
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_we) begin
            r_first_mem[i_cmd.addr_i]  <= i_first_coef;
            r_second_mem[i_cmd.addr_i] <= i_second_coef;
        end
        if (i_cmd.term_en) begin
            r_rd_a <= r_first_mem[i_cmd.addr_i];
            r_rd_b <= r_second_mem[i_cmd.addr_j];
        end
        if (i_cmd.term_en && i_cmd.term_first) begin
            r_a_k <= r_first_mem[i_cmd.addr_k];
            r_b_k <= r_second_mem[i_cmd.addr_k];
        end
    end

    // Term valid flags through the read, multiply and accumulate stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_f1 <= 1'b0;
            r_v2 <= 1'b0;
            r_f2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.term_en;
            r_f1 <= i_cmd.term_en & i_cmd.term_first;
            r_v2 <= r_v1;
            r_f2 <= r_f1;
        end
    end

    // Multiply, then accumulate; the first term of a power restarts the sum.
    always_ff @(posedge i_clk) begin
        r_prod <= r_rd_a * r_rd_b;
        if (r_v2) begin
            if (r_f2) begin
                r_acc <= PROD_W'(r_prod);
            end else begin
                r_acc <= r_acc + PROD_W'(r_prod);
            end
        end
    end

    // Coefficients above a polynomial's degree count as zero.
    assign a_k_masked = i_cmd.k_in_first  ? r_a_k : '0;
    assign b_k_masked = i_cmd.k_in_second ? r_b_k : '0;

    // Result register, loaded once the accumulator has settled.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sum      <= SUM_W'(a_k_masked) + SUM_W'(b_k_masked);
            r_diff     <= SUM_W'(a_k_masked) - SUM_W'(b_k_masked);
            r_out_prod <= r_acc;
        end
    end

    assign o_status.pipe_busy = r_v1 | r_v2;
    assign o_sum_coef         = r_sum;
    assign o_diff_coef        = r_diff;
    assign o_prod_coef        = r_out_prod;

endmodule

`default_nettype wire

FILE: hw/rtl/pasm_ctrl.sv
// ----------------------------------------------------------------------------
// pasm_ctrl
// Controller: degree registers, load handshake, power and term sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module pasm_ctrl #(
    parameter int MAX_DEGREE = pasm_pkg::MAX_DEGREE
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_cfg_we,
    input  wire logic [pasm_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [pasm_pkg::DEG_W-1:0]        i_cfg_data,
    input  wire                                    i_s_valid,
    input  wire                                    i_s_last,
    input  wire logic [pasm_pkg::POWER_W-1:0]      i_power,
    output logic                                   o_s_ready,
    output logic                                   o_m_valid,
    input  wire                                    i_m_ready,
    output logic [pasm_pkg::OUT_POWER_W-1:0]       o_out_power,
    output logic                                   o_final,
    output pasm_pkg::t_dp_cmd                      o_cmd,
    input  pasm_pkg::t_dp_status                   i_status
);
    import pasm_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD = 4'b0001,
        S_TERM = 4'b0010,
        S_WAIT = 4'b0100,
        S_SEND = 4'b1000
    } t_state;

    localparam logic [DEG_W-1:0]       MAX_DEG   = DEG_W'(MAX_DEGREE);
    localparam logic [OUT_POWER_W-1:0] MAX_DEG_K = OUT_POWER_W'(MAX_DEGREE);

    t_state                  r_state;
    t_state                  n_state;
    logic [DEG_W-1:0]        r_first_degree;
    logic [DEG_W-1:0]        r_second_degree;
    logic [OUT_POWER_W-1:0]  r_k;
    logic [OUT_POWER_W-1:0]  n_k;
    logic [POWER_W-1:0]      r_i;
    logic [POWER_W-1:0]      n_i;
    logic                    r_first_term;
    logic                    n_first_term;

    logic [DEG_W-1:0]        da;
    logic [DEG_W-1:0]        db;
    logic [POWER_W-1:0]      hi;

    // Lowest first-store index that contributes to power k.
    function automatic logic [POWER_W-1:0] low_index(input logic [OUT_POWER_W-1:0] k,
                                                     input logic [DEG_W-1:0] deg);
        logic [OUT_POWER_W-1:0] deg_k;
        deg_k = OUT_POWER_W'(deg);
        if (k > deg_k) begin
            return POWER_W'(k - deg_k);
        end
        return '0;
    endfunction

    // Degrees saturate at the largest supported degree.
    assign da = (r_first_degree  > MAX_DEG) ? MAX_DEG : r_first_degree;
    assign db = (r_second_degree > MAX_DEG) ? MAX_DEG : r_second_degree;
    assign hi = (r_k > OUT_POWER_W'(da)) ? POWER_W'(da) : POWER_W'(r_k);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_degree  <= '0;
            r_second_degree <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FIRST_DEGREE:  r_first_degree  <= i_cfg_data;
                CFG_SECOND_DEGREE: r_second_degree <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next-state and command logic.
    always_comb begin
        n_state      = r_state;
        n_k          = r_k;
        n_i          = r_i;
        n_first_term = r_first_term;
        o_s_ready    = 1'b0;
        o_m_valid    = 1'b0;

        o_cmd             = '0;
        o_cmd.addr_j      = POWER_W'(r_k - OUT_POWER_W'(r_i));
        o_cmd.addr_k      = (r_k > MAX_DEG_K) ? '0 : POWER_W'(r_k);
        o_cmd.k_in_first  = (r_k <= OUT_POWER_W'(da));
        o_cmd.k_in_second = (r_k <= OUT_POWER_W'(db));

        case (r_state)
            S_LOAD: begin
                o_s_ready    = 1'b1;
                o_cmd.addr_i = i_power;
                if (i_s_valid) begin
                    o_cmd.store_we = (i_power <= MAX_DEG);
                    if (i_s_last) begin
                        n_k          = OUT_POWER_W'(da) + OUT_POWER_W'(db);
                        n_i          = low_index(n_k, db);
                        n_first_term = 1'b1;
                        n_state      = S_TERM;
                    end
                end
            end
            S_TERM: begin
                o_cmd.term_en    = 1'b1;
                o_cmd.term_first = r_first_term;
                o_cmd.addr_i     = r_i;
                n_first_term     = 1'b0;
                if (r_i == hi) begin
                    n_state = S_WAIT;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            S_WAIT: begin
                if (!i_status.pipe_busy) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_SEND;
                end
            end
            S_SEND: begin
                o_m_valid = 1'b1;
                if (i_m_ready) begin
                    if (r_k == '0) begin
                        n_state = S_LOAD;
                    end else begin
                        n_k          = r_k - 1'b1;
                        n_i          = low_index(n_k, db);
                        n_first_term = 1'b1;
                        n_state      = S_TERM;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // Controller registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_k          <= '0;
            r_i          <= '0;
            r_first_term <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_k          <= n_k;
            r_i          <= n_i;
            r_first_term <= n_first_term;
        end
    end

    assign o_out_power = r_k;
    assign o_final     = (r_k == '0);

endmodule

`default_nettype wire

FILE: hw/rtl/polynomial_add_sub_mul.sv
// ----------------------------------------------------------------------------
// polynomial_add_sub_mul
// Sum, difference and product of two integer polynomials.
// ----------------------------------------------------------------------------
// Usage:
//   Set both degrees through the write port, then send coefficient pairs on
//   the slave stream, one beat per power. Each beat is stored at its power;
//   the beat with tlast set is stored too and starts the computation.
//   Loading accepts one beat per cycle. While the block computes and sends,
//   the slave side is not ready.
//   Results leave on the master stream from power da+db down to 0, one beat
//   per power, tlast on the power-zero beat. Each power issues its product
//   terms (at most min(da,db)+1) one per cycle through the store read ports
//   and the single multiplier, then drains the read, multiply and accumulate
//   stages and loads the result register before its beat is offered. The next
//   power starts the cycle after a beat is taken.
//   A stalled master side holds the beat and its data until tready.
//   Reset clears both degrees and returns the block to loading. The stores
//   are not cleared; every power within a degree must be loaded before use.
// ----------------------------------------------------------------------------
`default_nettype none

module polynomial_add_sub_mul #(
    parameter int MAX_DEGREE = pasm_pkg::MAX_DEGREE,
    parameter int COEF_WIDTH = pasm_pkg::COEF_WIDTH,
    localparam int S_TDATA_W = ((pasm_pkg::POWER_W + 2 * COEF_WIDTH + 7) / 8) * 8,
    localparam int M_BITS    = pasm_pkg::OUT_POWER_W + 2 * (COEF_WIDTH + 1)
                               + 2 * COEF_WIDTH + pasm_pkg::POWER_W,
    localparam int M_TDATA_W = ((M_BITS + 7) / 8) * 8
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    // Configuration write port.
    input  wire                                    i_cfg_we,
    input  wire logic [pasm_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [pasm_pkg::DEG_W-1:0]        i_cfg_data,
    // Coefficient stream.
    input  wire                                    i_s_tvalid,
    output logic                                   o_s_tready,
    input  wire logic [S_TDATA_W-1:0]              i_s_tdata,  // power, first_coef, second_coef
    input  wire                                    i_s_tlast,  // start_req
    // Result stream.
    output logic                                   o_m_tvalid,
    input  wire                                    i_m_tready,
    output logic [M_TDATA_W-1:0]                   o_m_tdata,  // out_power, sum, diff, prod
    output logic                                   o_m_tlast   // final_res
);
    import pasm_pkg::*;

    localparam int SUM_W  = COEF_WIDTH + 1;
    localparam int PROD_W = 2 * COEF_WIDTH + POWER_W;

    t_dp_cmd                      cmd;
    t_dp_status                   status;
    logic [POWER_W-1:0]           power;
    logic signed [COEF_WIDTH-1:0] first_coef;
    logic signed [COEF_WIDTH-1:0] second_coef;
    logic [OUT_POWER_W-1:0]       out_power;
    logic signed [SUM_W-1:0]      sum_coef;
    logic signed [SUM_W-1:0]      diff_coef;
    logic signed [PROD_W-1:0]     prod_coef;

    // Unpack the slave beat.
    assign power       = i_s_tdata[POWER_W-1:0];
    assign first_coef  = i_s_tdata[POWER_W +: COEF_WIDTH];
    assign second_coef = i_s_tdata[POWER_W + COEF_WIDTH +: COEF_WIDTH];

    pasm_ctrl #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_valid   (i_s_tvalid),
        .i_s_last    (i_s_tlast),
        .i_power     (power),
        .o_s_ready   (o_s_tready),
        .o_m_valid   (o_m_tvalid),
        .i_m_ready   (i_m_tready),
        .o_out_power (out_power),
        .o_final     (o_m_tlast),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    pasm_datapath #(
        .MAX_DEGREE (MAX_DEGREE),
        .COEF_WIDTH (COEF_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_first_coef  (first_coef),
        .i_second_coef (second_coef),
        .o_status      (status),
        .o_sum_coef    (sum_coef),
        .o_diff_coef   (diff_coef),
        .o_prod_coef   (prod_coef)
    );

    // Pack the master beat, zero-filled to whole bytes.
    assign o_m_tdata = M_TDATA_W'({prod_coef, diff_coef, sum_coef, out_power});

endmodule

`default_nettype wire

FILE: hw/rtl/pasm_checker.sv
// ----------------------------------------------------------------------------
// pasm_checker
// Port-level checks of the load, compute and send sequence.
// ----------------------------------------------------------------------------
`default_nettype none

`include "polynomial_add_sub_mul_defines.svh"

module pasm_checker #(
    parameter int DATA_W = 8
) (
    input wire                    i_clk,
    input wire                    i_rst_n,
    input wire                    i_s_valid,
    input wire                    i_s_ready,
    input wire                    i_s_last,
    input wire                    i_m_valid,
    input wire                    i_m_ready,
    input wire logic [DATA_W-1:0] i_m_data,
    input wire                    i_m_last
);

    logic s_beat;
    logic m_beat;

    assign s_beat = i_s_valid & i_s_ready;
    assign m_beat = i_m_valid & i_m_ready;

    // Loading and sending never overlap.
    `PASM_ASSERT_SAME(a_no_overlap, i_clk, i_rst_n, 1'b1, !(i_s_ready && i_m_valid))

    // A stalled result beat holds its data.
    `PASM_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_m_valid && !i_m_ready,
                      i_m_valid && $stable(i_m_data))

    // The start beat ends loading and no result is ready yet.
    `PASM_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, s_beat && i_s_last,
                      !i_s_ready && !i_m_valid)

    // A non-final result leads to further computing, not to loading.
    `PASM_ASSERT_NEXT(a_more_results, i_clk, i_rst_n, m_beat && !i_m_last,
                      !i_s_ready && !i_m_valid)

    // The final result returns the block to loading.
    `PASM_ASSERT_NEXT(a_final_load, i_clk, i_rst_n, m_beat && i_m_last, i_s_ready)

endmodule

bind polynomial_add_sub_mul pasm_checker #(
    .DATA_W (M_TDATA_W)
) u_pasm_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_s_valid (i_s_tvalid),
    .i_s_ready (o_s_tready),
    .i_s_last  (i_s_tlast),
    .i_m_valid (o_m_tvalid),
    .i_m_ready (i_m_tready),
    .i_m_data  (o_m_tdata),
    .i_m_last  (o_m_tlast)
);

`default_nettype wire

FILE: verif/polynomial_add_sub_mul_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_add_sub_mul_tb
// Self-checking bench for the polynomial sum, difference and product block.
// Coefficient pairs stream in under random source gaps. Every beat with
// tlast starts a run that a local predictor works out power by power. Each
// result beat, taken under random sink stalls, is checked field by field
// against the oldest predicted one. The degree registers change between
// phases, only while the block is quiet. A store entry is never read before
// it has been loaded.
// ----------------------------------------------------------------------------

module polynomial_add_sub_mul_tb;
    import pasm_pkg::*;

    // Stream layouts, lowest field first.
    localparam int S_TDATA_W = ((POWER_W + 2 * COEF_WIDTH + 7) / 8) * 8;
    localparam int SUM_W     = COEF_WIDTH + 1;
    localparam int PROD_W    = 2 * COEF_WIDTH + POWER_W;
    localparam int M_BITS    = OUT_POWER_W + 2 * SUM_W + PROD_W;
    localparam int M_TDATA_W = ((M_BITS + 7) / 8) * 8;
    localparam int FIRST_LO  = POWER_W;
    localparam int SECOND_LO = POWER_W + COEF_WIDTH;
    localparam int SUM_LO    = OUT_POWER_W;
    localparam int DIFF_LO   = SUM_LO + SUM_W;
    localparam int PROD_LO   = DIFF_LO + SUM_W;
    localparam int DEPTH     = 32;

    // Run length, quiet-time, watchdog and print-limit settings.
    localparam int RANDOM_PAIRS = 400;
    localparam int SETTLE       = 40;
    localparam int STALL_LIMIT  = 3000;
    localparam int MAX_PRINTS   = 30;

    typedef struct packed {
        logic [POWER_W-1:0]           power;
        logic signed [COEF_WIDTH-1:0] first;
        logic signed [COEF_WIDTH-1:0] second;
        logic                         start;
    } coef_pair_t;

    typedef struct packed {
        logic [OUT_POWER_W-1:0]   power;
        logic signed [SUM_W-1:0]  sum;
        logic signed [SUM_W-1:0]  diff;
        logic signed [PROD_W-1:0] prod;
        logic                     last;
    } poly_term_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [DEG_W-1:0]       i_cfg_data = '0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [S_TDATA_W-1:0]   i_s_tdata = '0;  // power, first_coef, second_coef
    logic                   i_s_tlast = 1'b0;  // start_req
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   o_m_tdata;  // out_power, sum, diff, prod
    logic                   o_m_tlast;  // final_res

    polynomial_add_sub_mul i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    // Predictor state: both coefficient stores and the degree registers.
    logic signed [COEF_WIDTH-1:0] first_coefs [DEPTH];
    logic signed [COEF_WIDTH-1:0] second_coefs [DEPTH];
    logic [DEG_W-1:0]             first_deg = '0;
    logic [DEG_W-1:0]             second_deg = '0;

    coef_pair_t pending_pairs [$];
    poly_term_t expected_terms [$];
    coef_pair_t next_pair;
    bit [DEPTH-1:0] loaded_mask = '0;  // powers queued for loading since reset, one bit per power

    bit pair_taken = 1'b0;
    bit no_idle_phase = 1'b0;
    int src_gap = 0;
    int sink_hold = 0;
    int error_count = 0;
    int pairs_queued = 0;
    int pairs_taken = 0;
    int terms_checked = 0;
    int runs_started = 0;
    int phase_count = 0;
    int stall_cycles = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Gap lengths: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle_phase || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Coefficients: full random range with frequent extreme values.
    function automatic logic signed [COEF_WIDTH-1:0] pick_coef();
        case ($urandom_range(0, 11))
            0: return {1'b1, {(COEF_WIDTH - 1){1'b0}}};
            1: return {1'b0, {(COEF_WIDTH - 1){1'b1}}};
            2: return '0;
            3: return '1;
            default: return COEF_WIDTH'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTS) $display("ERROR at %0t ns: %s", $realtime, msg);
    endtask

    // Store one pair; on a start, predict every result beat of the run.
    task automatic accept_pair(input coef_pair_t pair);
        int top;
        int larger;
        logic signed [COEF_WIDTH-1:0] a;
        logic signed [COEF_WIDTH-1:0] b;
        logic signed [63:0] acc;
        poly_term_t term;
        first_coefs[pair.power] = pair.first;
        second_coefs[pair.power] = pair.second;
        pairs_taken++;
        if (pair.start) begin
            runs_started++;
            top = int'(first_deg) + int'(second_deg);
            larger = (first_deg > second_deg) ? int'(first_deg) : int'(second_deg);
            for (int k = top; k >= 0; k--) begin
                a = (k <= int'(first_deg)) ? first_coefs[k] : '0;
                b = (k <= int'(second_deg)) ? second_coefs[k] : '0;
                acc = '0;
                for (int i = 0; i <= int'(first_deg); i++) begin
                    if (i <= k && k - i <= int'(second_deg))
                        acc += first_coefs[i] * second_coefs[k - i];
                end
                term.power = OUT_POWER_W'(k);
                term.sum = (k <= larger) ? {a[COEF_WIDTH-1], a} + {b[COEF_WIDTH-1], b} : '0;
                term.diff = (k <= larger) ? {a[COEF_WIDTH-1], a} - {b[COEF_WIDTH-1], b} : '0;
                term.prod = acc[PROD_W-1:0];
                term.last = (k == 0);
                expected_terms.push_back(term);
            end
        end
    endtask

    // Compare one result beat with the oldest prediction.
    task automatic check_term(input poly_term_t got);
        poly_term_t want;
        terms_checked++;
        if (expected_terms.size() == 0) begin
            report_mismatch($sformatf("result beat for power %0d with none expected", got.power));
        end else begin
            want = expected_terms.pop_front();
            if (got.power !== want.power)
                report_mismatch($sformatf("power got %0d expected %0d", got.power, want.power));
            if (got.sum !== want.sum)
                report_mismatch($sformatf("power %0d sum got %0d expected %0d",
                                          want.power, got.sum, want.sum));
            if (got.diff !== want.diff)
                report_mismatch($sformatf("power %0d diff got %0d expected %0d",
                                          want.power, got.diff, want.diff));
            if (got.prod !== want.prod)
                report_mismatch($sformatf("power %0d product got %0d expected %0d",
                                          want.power, got.prod, want.prod));
            if (got.last !== want.last)
                report_mismatch($sformatf("power %0d tlast got %0b expected %0b",
                                          want.power, got.last, want.last));
        end
    endtask

    // Monitor: sample both streams at the rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pair_taken <= 1'b0;
        end else begin
            pair_taken <= i_s_tvalid && o_s_tready;
            if (i_s_tvalid && o_s_tready)
                accept_pair({i_s_tdata[POWER_W-1:0], i_s_tdata[FIRST_LO +: COEF_WIDTH],
                             i_s_tdata[SECOND_LO +: COEF_WIDTH], i_s_tlast});
            if (o_m_tvalid && i_m_tready)
                check_term({o_m_tdata[OUT_POWER_W-1:0], o_m_tdata[SUM_LO +: SUM_W],
                            o_m_tdata[DIFF_LO +: SUM_W], o_m_tdata[PROD_LO +: PROD_W],
                            o_m_tlast});
        end
    end

    // Driver: offer the next pending pair once the current beat is gone.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || pair_taken) begin
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                i_s_tvalid <= 1'b0;
            end else if (pending_pairs.size() > 0) begin
                next_pair = pending_pairs.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata <= S_TDATA_W'({next_pair.second, next_pair.first, next_pair.power});
                i_s_tlast <= next_pair.start;
                src_gap <= pick_gap();
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Sink: random stalls on the result stream.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= (sink_hold == 0);
            sink_hold <= (sink_hold == 0) ? pick_gap() : sink_hold - 1;
        end
    end

    // Watchdog: give up when neither stream moves for too long.
    initial begin : watchdog
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_we)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("ERROR: no beat moved for %0d cycles", STALL_LIMIT);
        $display("FAILURE");
        $finish;
    end

    task automatic queue_pair(input int power, input logic signed [COEF_WIDTH-1:0] first,
                              input logic signed [COEF_WIDTH-1:0] second, input bit start);
        coef_pair_t pair;
        pair.power = POWER_W'(power);
        pair.first = first;
        pair.second = second;
        pair.start = start;
        pending_pairs.push_back(pair);
        loaded_mask[power] = 1'b1;
        pairs_queued++;
    endtask

    // Load every power up to the larger degree that has never been loaded.
    task automatic fill_unloaded(input int upto);
        for (int p = 0; p <= upto; p++) begin
            if (!loaded_mask[p]) queue_pair(p, pick_coef(), pick_coef(), 1'b0);
        end
    endtask

    // Wait until every pair is sent and every result has arrived.
    task automatic wait_quiet(input int extra);
        while (pending_pairs.size() > 0 || i_s_tvalid || expected_terms.size() > 0)
            @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_degree(input t_cfg_index index, input int value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= DEG_W'(value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (index == CFG_FIRST_DEGREE) first_deg = DEG_W'(value);
        else second_deg = DEG_W'(value);
    endtask

    task automatic set_degrees(input int da, input int db);
        wait_quiet(8);
        write_degree(CFG_FIRST_DEGREE, da);
        write_degree(CFG_SECOND_DEGREE, db);
        phase_count++;
    endtask

    // A full load of powers 0..n-1, usually in shuffled order, start on the last beat.
    task automatic queue_full_frame(input int n, input bit all_min);
        int order [DEPTH];
        int j;
        int tmp;
        logic signed [COEF_WIDTH-1:0] lowest;
        lowest = {1'b1, {(COEF_WIDTH - 1){1'b0}}};
        for (int p = 0; p < n; p++) order[p] = p;
        if ($urandom_range(0, 2) != 0) begin
            for (int p = n - 1; p > 0; p--) begin
                j = $urandom_range(0, p);
                tmp = order[p];
                order[p] = order[j];
                order[j] = tmp;
            end
        end
        for (int p = 0; p < n; p++) begin
            if (all_min) queue_pair(order[p], lowest, lowest, p == n - 1);
            else queue_pair(order[p], pick_coef(), pick_coef(), p == n - 1);
        end
    endtask

    // Directed beats, then random phases of frames, noise and early starts.
    initial begin : stimulus
        int da;
        int db;
        int n_frames;
        int kind;
        int directed_pairs;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Degrees zero after reset: a single most-negative pair.
        queue_pair(0, 16'sh8000, 16'sh8000, 1'b1);
        wait_quiet(0);

        // Unequal degrees with the second longer, extremes at most powers,
        // a stored-only beat at the top power and a second start.
        set_degrees(2, 3);
        queue_pair(0, 16'sh7fff, 16'sh8000, 1'b0);
        queue_pair(1, 16'shffff, 16'sh7fff, 1'b0);
        queue_pair(2, 16'sh8000, 16'shffff, 1'b0);
        queue_pair(3, 16'sh0005, 16'sh7fff, 1'b1);
        queue_pair(31, 16'sh7fff, 16'shffff, 1'b0);
        queue_pair(0, 16'sh8000, 16'sh7fff, 1'b1);

        // First longer, so sum and difference vanish above its degree only.
        set_degrees(3, 1);
        queue_pair(2, 16'sh1234, 16'sh7fff, 1'b0);
        queue_pair(3, 16'sh8000, 16'sh0000, 1'b1);
        directed_pairs = pairs_queued;

        while (pairs_queued - directed_pairs < RANDOM_PAIRS) begin
            case (phase_count)
                3: begin da = 31; db = 31; end
                4: begin da = 0; db = 31; end
                5: begin da = 31; db = 0; end
                6: begin da = 0; db = 0; end
                default: begin
                    da = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 5)
                                                       : $urandom_range(6, 31);
                    db = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 5)
                                                       : $urandom_range(6, 31);
                end
            endcase
            set_degrees(da, db);
            no_idle_phase = ($urandom_range(0, 4) == 0);
            n_frames = (da + db > 20) ? 1 : $urandom_range(1, 4);
            for (int f = 0; f < n_frames; f++) begin
                kind = $urandom_range(0, 99);
                if (kind < 70 || (da + db > 20 && kind < 85)) begin
                    queue_full_frame(((da > db) ? da : db) + 1, $urandom_range(0, 9) == 0);
                end else if (kind < 85) begin
                    // Overwrites at random powers that start nothing.
                    repeat ($urandom_range(1, 5))
                        queue_pair($urandom_range(0, 31), pick_coef(), pick_coef(), 1'b0);
                end else begin
                    // Partial reload, then an early start at any power.
                    repeat ($urandom_range(0, 4))
                        queue_pair($urandom_range(0, 31), pick_coef(), pick_coef(), 1'b0);
                    fill_unloaded((da > db) ? da : db);
                    queue_pair($urandom_range(0, 31), pick_coef(), pick_coef(), 1'b1);
                end
            end
        end

        wait_quiet(SETTLE);
        $display("Run covered %0d coefficient beats in %0d degree settings.",
                 pairs_taken, phase_count + 1);
        $display("%0d computations started, %0d result beats checked, %0d mismatches.",
                 runs_started, terms_checked, error_count);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
